// ===== hdl/aesb_pkg.sv =====
// shared constants, types and byte functions for the aes-192 block cipher
package aesb_pkg;

    localparam int NUM_ROUNDS = 12;
    localparam int KEY_COUNT  = NUM_ROUNDS + 1;
    localparam int KEY_AW     = $clog2(KEY_COUNT);

    localparam logic [KEY_AW-1:0] LAST_ROUND = KEY_AW'(NUM_ROUNDS);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ENC  = 1'b1;
    localparam logic HALF_HI   = 1'b0;
    localparam logic HALF_LO   = 1'b1;

    typedef logic [127:0] block_t;

    // which steps the shared round unit applies in a given cycle
    typedef struct packed {
        logic sub_en;
        logic mix_en;
    } round_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== hdl/aesb_if.sv =====
// valid/ready channel interfaces for request and result items
interface aesb_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  key_index;
    logic        key_half;
    logic [63:0] data_hi;
    logic [63:0] data_lo;

    modport source (output valid, mode, key_index, key_half, data_hi, data_lo, input ready);
    modport sink   (input valid, mode, key_index, key_half, data_hi, data_lo, output ready);
endinterface

interface aesb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;

    modport source (output valid, cipher_hi, cipher_lo, input ready);
    modport sink   (input valid, cipher_hi, cipher_lo, output ready);
endinterface

// ===== hdl/aesb_key_store.sv =====
// round key memory: two 64-bit halves per key, registered read
module aesb_key_store (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [aesb_pkg::KEY_AW-1:0] wr_idx,
    input  logic                       wr_half,
    input  logic [63:0]                wr_data,
    input  logic [aesb_pkg::KEY_AW-1:0] rd_idx,
    output aesb_pkg::block_t           rd_key
);

    logic [63:0] hi_mem [aesb_pkg::KEY_COUNT];
    logic [63:0] lo_mem [aesb_pkg::KEY_COUNT];
    logic [63:0] rd_hi_reg;
    logic [63:0] rd_lo_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_half == aesb_pkg::HALF_HI)
        begin
            hi_mem[wr_idx] <= wr_data;
        end
        if (wr_en && wr_half == aesb_pkg::HALF_LO)
        begin
            lo_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_hi_reg <= hi_mem[rd_idx];
        rd_lo_reg <= lo_mem[rd_idx];
    end

    assign rd_key = {rd_hi_reg, rd_lo_reg};

endmodule

// ===== hdl/aesb_round.sv =====
// shared round unit: optional subbytes+shiftrows, optional mixcolumns, then key add
module aesb_round (
    input  aesb_pkg::block_t      state_in,
    input  aesb_pkg::block_t      round_key,
    input  aesb_pkg::round_ctrl_t ctrl,
    output aesb_pkg::block_t      state_out
);

    logic [7:0] s   [16];
    logic [7:0] t   [16];
    logic [7:0] m   [16];
    logic [7:0] sel [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8*i -: 8];
        end
        // byte at row r of column c comes from column c+r
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[c*4 + r] = aesb_pkg::SBOX[s[((c + r) % 4)*4 + r]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[c*4 + 0] = aesb_pkg::xtime(t[c*4]) ^ aesb_pkg::xtime(t[c*4+1]) ^ t[c*4+1]
                         ^ t[c*4+2] ^ t[c*4+3];
            m[c*4 + 1] = t[c*4] ^ aesb_pkg::xtime(t[c*4+1]) ^ aesb_pkg::xtime(t[c*4+2])
                         ^ t[c*4+2] ^ t[c*4+3];
            m[c*4 + 2] = t[c*4] ^ t[c*4+1] ^ aesb_pkg::xtime(t[c*4+2])
                         ^ aesb_pkg::xtime(t[c*4+3]) ^ t[c*4+3];
            m[c*4 + 3] = aesb_pkg::xtime(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2]
                         ^ aesb_pkg::xtime(t[c*4+3]);
        end
        for (int i = 0; i < 16; i++)
        begin
            if (!ctrl.sub_en)
            begin
                sel[i] = s[i];
            end
            else if (ctrl.mix_en)
            begin
                sel[i] = m[i];
            end
            else
            begin
                sel[i] = t[i];
            end
            state_out[127 - 8*i -: 8] = sel[i] ^ round_key[127 - 8*i -: 8];
        end
    end

endmodule

// ===== hdl/aes192_block_encrypt_top.sv =====
// aes-192 encryption top level: sequencer around the key store and shared round unit
// encrypt request: initial key add + 12 rounds, one pass of the shared round unit per
// cycle (the final pass waits while an older result is unclaimed), key words prefetched
// from the key store; no new request is accepted until the result has been registered
// load request: accepted every cycle while idle, writes one key half (index 0-12), no result
// reset clears the sequencer and output valid; the key store is not cleared
module aes192_block_encrypt_top (
    input logic       clk,
    input logic       rst_n,
    aesb_in_if.sink   data_ch,
    aesb_out_if.source result_ch
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } fsm_t;

    fsm_t                         fsm_reg, fsm_next;
    logic [aesb_pkg::KEY_AW-1:0]  round_reg, round_next;
    aesb_pkg::block_t             state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;
    aesb_pkg::block_t             cipher_reg, cipher_next;

    logic                         accept;
    logic                         last;
    logic                         finish;
    logic                         key_wr_en;
    logic [aesb_pkg::KEY_AW-1:0]  rd_idx;
    aesb_pkg::block_t             round_key;
    aesb_pkg::block_t             round_out;
    aesb_pkg::round_ctrl_t        ctrl;

    assign data_ch.ready = (fsm_reg == ST_IDLE);
    assign accept        = data_ch.valid && data_ch.ready;
    assign last          = (fsm_reg == ST_RUN) && (round_reg == aesb_pkg::LAST_ROUND);
    // final round waits while an older result is still unclaimed
    assign finish        = last && (!out_valid_reg || result_ch.ready);

    assign key_wr_en = accept && data_ch.mode == aesb_pkg::MODE_LOAD
                       && data_ch.key_index <= 4'(aesb_pkg::NUM_ROUNDS);

    // prefetch the key for the next pass; hold the last key while stalled
    always_comb
    begin
        if (fsm_reg == ST_RUN)
        begin
            rd_idx = last ? round_reg : round_reg + 1'b1;
        end
        else
        begin
            rd_idx = '0;
        end
    end

    assign ctrl.sub_en = (round_reg != '0);
    assign ctrl.mix_en = (round_reg != '0) && (round_reg != aesb_pkg::LAST_ROUND);

    aesb_key_store u_key_store (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_idx  (data_ch.key_index[aesb_pkg::KEY_AW-1:0]),
        .wr_half (data_ch.key_half),
        .wr_data (data_ch.key_half == aesb_pkg::HALF_LO ? data_ch.data_lo : data_ch.data_hi),
        .rd_idx  (rd_idx),
        .rd_key  (round_key)
    );

    aesb_round u_round (
        .state_in  (state_reg),
        .round_key (round_key),
        .ctrl      (ctrl),
        .state_out (round_out)
    );

    always_comb
    begin
        fsm_next       = fsm_reg;
        round_next     = round_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cipher_next    = cipher_reg;

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (accept && data_ch.mode == aesb_pkg::MODE_ENC)
                begin
                    state_next = {data_ch.data_hi, data_ch.data_lo};
                    round_next = '0;
                    fsm_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!last)
                begin
                    state_next = round_out;
                    round_next = round_reg + 1'b1;
                end
                else if (finish)
                begin
                    cipher_next    = round_out;
                    out_valid_next = 1'b1;
                    fsm_next       = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg  <= state_next;
        cipher_reg <= cipher_next;
    end

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.cipher_hi = cipher_reg[127:64];
    assign result_ch.cipher_lo = cipher_reg[63:0];

endmodule

// ===== hdl/aesb_checker.sv =====
// port-level checker for the aes-192 encryption top level, with its bind
module aesb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_mode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] cipher_hi,
    input logic [63:0] cipher_lo
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cipher_hi) && $stable(cipher_lo))
        else $error("result changed while stalled");

    a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_mode == aesb_pkg::MODE_ENC |=> !in_ready)
        else $error("ready stayed high after encrypt request");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_mode == aesb_pkg::MODE_LOAD |=> in_ready)
        else $error("key load made the block busy");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an encryption in flight");

endmodule

bind aes192_block_encrypt_top aesb_checker u_aesb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data_ch.valid),
    .in_ready  (data_ch.ready),
    .in_mode   (data_ch.mode),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .cipher_hi (result_ch.cipher_hi),
    .cipher_lo (result_ch.cipher_lo)
);
